// ----- src/sfd_pkg.sv -----
// package for the sync frame deframer: frame geometry, widths and codes
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

    localparam int PAYLOAD_LEN = 444;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int SEQ_W   = 16;
    localparam int INDEX_W = 9;
    localparam int POS_W   = $clog2(PAYLOAD_LEN + 8);

    localparam logic [BYTE_W-1:0] HDR_A     = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_B     = 8'h55;
    localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h0D;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;

    // body byte positions after the header
    localparam logic [POS_W-1:0] POS_SEQ_LO  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SEQ_HI  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PAY_0   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_PAY_END = POS_W'(4 + PAYLOAD_LEN);
    localparam logic [POS_W-1:0] POS_SNAP    = POS_W'(3 + PAYLOAD_LEN);
    localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(4 + PAYLOAD_LEN);
    localparam logic [POS_W-1:0] POS_CRC_HI  = POS_W'(5 + PAYLOAD_LEN);
    localparam logic [POS_W-1:0] POS_TAIL_0  = POS_W'(6 + PAYLOAD_LEN);

    localparam logic [SEQ_W-1:0] LEN_EXPECT = SEQ_W'(PAYLOAD_LEN);

    typedef enum logic [1:0] {
        ERR_OK  = 2'd0,
        ERR_LEN = 2'd1,
        ERR_CRC = 2'd2
    } t_err;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

endpackage

`default_nettype wire

// ----- src/sfd_byte_if.sv -----
// handshake channel carrying one received byte per item
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sfd_byte_if
    import sfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/sfd_res_if.sv -----
// handshake channel carrying one result item: payload byte or frame verdict
// depends on sfd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sfd_res_if
    import sfd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [BYTE_W-1:0]  data_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_ok;
    logic [1:0]         error_code;
    logic [SEQ_W-1:0]   frame_seq;
    logic               seq_gap;
    logic [SEQ_W-1:0]   lost_count;
    logic [CRC_W-1:0]   computed_crc;

    modport source (
        output valid, output kind, output data_byte, output byte_index,
        output frame_ok, output error_code, output frame_seq, output seq_gap,
        output lost_count, output computed_crc, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input byte_index,
        input frame_ok, input error_code, input frame_seq, input seq_gap,
        input lost_count, input computed_crc, output ready
    );
endinterface

`default_nettype wire

// ----- src/sync_frame_deframer_crc16.sv -----
// path: an accepted byte passes the input register, then the result register, to its result
// throughput: one byte per cycle, sustained while the result side keeps taking items
// bytes of header, seq, len, crc and first tail give no result; payload bytes and the
// last tail byte each give one
// reset: synchronous, active low; hunts for the header, lost counter cleared
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_deframer_crc16
    import sfd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    sfd_byte_if.sink   i_rx,
    sfd_res_if.source  o_res
);

    sfd_byte_if u_mid ();

    sfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .o_rx    (u_mid.source)
    );

    sfd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (u_mid.sink),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ----- src/sfd_in_stage.sv -----
// input register stage: captures one received byte per item
// depends on sfd_pkg and sfd_byte_if
`timescale 1ns / 1ps
`default_nettype none

module sfd_in_stage
    import sfd_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    sfd_byte_if.sink      i_rx,
    sfd_byte_if.source    o_rx
);

    logic              r_vld;
    logic [BYTE_W-1:0] r_byte;

    assign i_rx.ready = !r_vld || o_rx.ready;
    assign o_rx.valid = r_vld;
    assign o_rx.rx_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_vld <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ----- src/sfd_core.sv -----
// frame state, crc-16/modbus update, verdict logic and result register
// depends on sfd_pkg, sfd_byte_if and sfd_res_if
`timescale 1ns / 1ps
`default_nettype none

module sfd_core
    import sfd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    sfd_byte_if.sink   i_rx,
    sfd_res_if.source  o_res
);

    typedef enum logic [1:0] {
        ST_WAIT_A = 2'd0,
        ST_WAIT_B = 2'd1,
        ST_BODY   = 2'd2
    } t_state;

    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  c_in,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CRC_W-1:0] r_crc, n_crc;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic [SEQ_W-1:0] r_len, n_len;
    logic [CRC_W-1:0] r_snap, n_snap;
    logic [CRC_W-1:0] r_rxcrc, n_rxcrc;
    logic [BYTE_W-1:0] r_tail, n_tail;
    logic [SEQ_W-1:0] r_prev_seq, n_prev_seq;
    logic             r_prev_known, n_prev_known;
    logic [SEQ_W-1:0] r_gap_cnt, n_gap_cnt;

    logic               r_out_vld, n_out_vld;
    t_kind              r_kind, n_kind;
    logic [BYTE_W-1:0]  r_data, n_data;
    logic [INDEX_W-1:0] r_index, n_index;
    logic               r_ok, n_ok;
    t_err               r_err, n_err;
    logic [SEQ_W-1:0]   r_fseq, n_fseq;
    logic               r_gap, n_gap;
    logic [SEQ_W-1:0]   r_lost, n_lost;
    logic [CRC_W-1:0]   r_ccrc, n_ccrc;

    logic               w_fire;
    logic [BYTE_W-1:0]  w_b;
    logic [CRC_W-1:0]   w_crc_next;
    logic [INDEX_W-1:0] w_idx;

    assign i_rx.ready = !r_out_vld || o_res.ready;
    assign w_fire     = i_rx.valid && i_rx.ready;
    assign w_b        = i_rx.rx_byte;
    assign w_crc_next = crc_byte(r_crc, w_b);
    assign w_idx      = INDEX_W'(r_pos - POS_PAY_0);

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_crc        = r_crc;
        n_seq        = r_seq;
        n_len        = r_len;
        n_snap       = r_snap;
        n_rxcrc      = r_rxcrc;
        n_tail       = r_tail;
        n_prev_seq   = r_prev_seq;
        n_prev_known = r_prev_known;
        n_gap_cnt    = r_gap_cnt;
        n_out_vld    = r_out_vld && !o_res.ready;
        n_kind       = r_kind;
        n_data       = r_data;
        n_index      = r_index;
        n_ok         = r_ok;
        n_err        = r_err;
        n_fseq       = r_fseq;
        n_gap        = r_gap;
        n_lost       = r_lost;
        n_ccrc       = r_ccrc;

        if (w_fire) begin
            unique case (r_state)
                ST_WAIT_B: begin
                    if (w_b == HDR_B) begin
                        n_state = ST_BODY;
                        n_pos   = '0;
                        n_crc   = CRC_INIT;
                    end else if (w_b != HDR_A) begin
                        n_state = ST_WAIT_A;
                    end
                end
                ST_BODY: begin
                    n_pos = r_pos + POS_W'(1);
                    if (r_pos < POS_PAY_END) begin
                        n_crc = w_crc_next;
                        if (r_pos == POS_SEQ_LO) begin
                            n_seq = {{(SEQ_W-BYTE_W){1'b0}}, w_b};
                        end
                        if (r_pos == POS_SEQ_HI) begin
                            n_seq = {w_b, r_seq[BYTE_W-1:0]};
                        end
                        if (r_pos == POS_LEN_LO) begin
                            n_len = {{(SEQ_W-BYTE_W){1'b0}}, w_b};
                        end
                        if (r_pos == POS_LEN_HI) begin
                            n_len = {w_b, r_len[BYTE_W-1:0]};
                        end
                        if (r_pos == POS_SNAP) begin
                            n_snap = w_crc_next;
                        end
                        if (r_pos >= POS_PAY_0) begin
                            n_out_vld = 1'b1;
                            n_kind    = KIND_DATA;
                            n_data    = w_b;
                            n_index   = w_idx;
                            n_ok      = 1'b0;
                            n_err     = ERR_OK;
                            n_fseq    = '0;
                            n_gap     = 1'b0;
                            n_lost    = '0;
                            n_ccrc    = '0;
                        end
                    end else if (r_pos == POS_CRC_LO) begin
                        n_rxcrc = {{(CRC_W-BYTE_W){1'b0}}, w_b};
                    end else if (r_pos == POS_CRC_HI) begin
                        n_rxcrc = {w_b, r_rxcrc[BYTE_W-1:0]};
                    end else if (r_pos == POS_TAIL_0) begin
                        n_tail = w_b;
                    end else begin
                        // last tail byte: verdict
                        if (r_len != LEN_EXPECT || r_tail != TAIL_BYTE
                                || w_b != TAIL_BYTE) begin
                            n_err = ERR_LEN;
                        end else if (r_rxcrc != r_snap) begin
                            n_err = ERR_CRC;
                        end else begin
                            n_err = ERR_OK;
                        end
                        n_gap = 1'b0;
                        if (n_err == ERR_OK) begin
                            if (r_prev_known && r_seq != r_prev_seq + SEQ_W'(1)) begin
                                n_gap     = 1'b1;
                                n_gap_cnt = r_gap_cnt + SEQ_W'(1);
                            end
                            n_prev_seq   = r_seq;
                            n_prev_known = 1'b1;
                        end
                        n_state   = ST_WAIT_A;
                        n_pos     = '0;
                        n_out_vld = 1'b1;
                        n_kind    = KIND_VERDICT;
                        n_data    = '0;
                        n_index   = '0;
                        n_ok      = (n_err == ERR_OK);
                        n_fseq    = r_seq;
                        n_lost    = n_gap_cnt;
                        n_ccrc    = r_snap;
                    end
                end
                default: begin
                    n_state = (w_b == HDR_A) ? ST_WAIT_B : ST_WAIT_A;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_WAIT_A;
            r_pos        <= '0;
            r_crc        <= CRC_INIT;
            r_seq        <= '0;
            r_len        <= '0;
            r_snap       <= '0;
            r_rxcrc      <= '0;
            r_tail       <= '0;
            r_prev_seq   <= '0;
            r_prev_known <= 1'b0;
            r_gap_cnt    <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_crc        <= n_crc;
            r_seq        <= n_seq;
            r_len        <= n_len;
            r_snap       <= n_snap;
            r_rxcrc      <= n_rxcrc;
            r_tail       <= n_tail;
            r_prev_seq   <= n_prev_seq;
            r_prev_known <= n_prev_known;
            r_gap_cnt    <= n_gap_cnt;
            r_out_vld    <= n_out_vld;
        end
        r_kind  <= n_kind;
        r_data  <= n_data;
        r_index <= n_index;
        r_ok    <= n_ok;
        r_err   <= n_err;
        r_fseq  <= n_fseq;
        r_gap   <= n_gap;
        r_lost  <= n_lost;
        r_ccrc  <= n_ccrc;
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.kind         = r_kind;
    assign o_res.data_byte    = r_data;
    assign o_res.byte_index   = r_index;
    assign o_res.frame_ok     = r_ok;
    assign o_res.error_code   = r_err;
    assign o_res.frame_seq    = r_fseq;
    assign o_res.seq_gap      = r_gap;
    assign o_res.lost_count   = r_lost;
    assign o_res.computed_crc = r_ccrc;

endmodule

`default_nettype wire

// ----- tb/tb_sync_frame_deframer_crc16.sv -----
// self-checking bench for sync_frame_deframer_crc16: hunting, framing, crc, tail and seq checks
// depends on sfd_pkg, sfd_byte_if, sfd_res_if and the deframer rtl
`timescale 1ns / 1ps

module tb_sync_frame_deframer_crc16;
    import sfd_pkg::*;

    localparam longint LIMIT_NS   = 64'd5_000_000;
    localparam int     LONG_HOLD  = 400;

    typedef enum logic [1:0] {HUNT_AA, HUNT_55, IN_BODY} t_hunt;
    typedef enum int {FR_GOOD, FR_BAD_LEN, FR_BAD_CRC, FR_BAD_TAIL0, FR_BAD_TAIL1,
                      FR_BAD_LEN_CRC, FR_CUT} t_frame_fault;
    typedef enum int {PACE_FULL, PACE_COIN, PACE_TWO_OF_THREE, PACE_SPARSE} t_rx_pace;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               frame_ok;
        logic [1:0]         error_code;
        logic [SEQ_W-1:0]   frame_seq;
        logic               seq_gap;
        logic [SEQ_W-1:0]   lost_count;
        logic [CRC_W-1:0]   computed_crc;
    } t_result;

    class deframer_model;
        t_hunt             hunt;
        int unsigned       body_pos;
        logic [CRC_W-1:0]  crc_run;
        logic [CRC_W-1:0]  crc_at_end;
        logic [CRC_W-1:0]  crc_rx;
        logic [SEQ_W-1:0]  seq_rx;
        logic [SEQ_W-1:0]  len_rx;
        logic [BYTE_W-1:0] tail_first;
        logic [SEQ_W-1:0]  prior_seq;
        bit                prior_seq_valid;
        logic [SEQ_W-1:0]  lost_frames;
        t_result           deframed_q[$];
        int unsigned       mismatches;

        function new();
            hunt            = HUNT_AA;
            body_pos        = 0;
            crc_run         = CRC_INIT;
            crc_at_end      = '0;
            crc_rx          = '0;
            seq_rx          = '0;
            len_rx          = '0;
            tail_first      = '0;
            prior_seq       = '0;
            prior_seq_valid = 1'b0;
            lost_frames     = '0;
            mismatches      = 0;
        endfunction

        static function logic [CRC_W-1:0] crc16_update(logic [CRC_W-1:0] c,
                                                       logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] r;
            r = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            int unsigned p;
            t_result     r;
            bit          gap;
            r   = '0;
            gap = 1'b0;
            if (hunt == HUNT_55) begin
                if (b == HDR_B) begin
                    hunt     = IN_BODY;
                    body_pos = 0;
                    crc_run  = CRC_INIT;
                end else if (b != HDR_A) begin
                    hunt = HUNT_AA;
                end
            end else if (hunt != IN_BODY) begin
                hunt = (b == HDR_A) ? HUNT_55 : HUNT_AA;
            end else begin
                p        = body_pos;
                body_pos = p + 1;
                if (p < 4 + PAYLOAD_LEN) begin
                    crc_run = crc16_update(crc_run, b);
                    if (p == 0) seq_rx = {8'h00, b};
                    else if (p == 1) seq_rx[15:8] = b;
                    else if (p == 2) len_rx = {8'h00, b};
                    else if (p == 3) len_rx[15:8] = b;
                    if (p == 3 + PAYLOAD_LEN) crc_at_end = crc_run;
                    if (p >= 4) begin
                        r.kind       = KIND_DATA;
                        r.data_byte  = b;
                        r.byte_index = INDEX_W'(p - 4);
                        deframed_q.push_back(r);
                    end
                end else if (p == 4 + PAYLOAD_LEN) begin
                    crc_rx = {8'h00, b};
                end else if (p == 5 + PAYLOAD_LEN) begin
                    crc_rx[15:8] = b;
                end else if (p == 6 + PAYLOAD_LEN) begin
                    tail_first = b;
                end else begin
                    if (len_rx != LEN_EXPECT || tail_first != TAIL_BYTE || b != TAIL_BYTE)
                        r.error_code = ERR_LEN;
                    else if (crc_rx != crc_at_end)
                        r.error_code = ERR_CRC;
                    else
                        r.error_code = ERR_OK;
                    if (r.error_code == ERR_OK) begin
                        if (prior_seq_valid && seq_rx != prior_seq + 16'd1) begin
                            gap         = 1'b1;
                            lost_frames = lost_frames + 16'd1;
                        end
                        prior_seq       = seq_rx;
                        prior_seq_valid = 1'b1;
                    end
                    hunt           = HUNT_AA;
                    body_pos       = 0;
                    r.kind         = KIND_VERDICT;
                    r.frame_ok     = (r.error_code == ERR_OK);
                    r.frame_seq    = seq_rx;
                    r.seq_gap      = gap;
                    r.lost_count   = lost_frames;
                    r.computed_crc = crc_at_end;
                    deframed_q.push_back(r);
                end
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
                mismatches++;
            end
        endfunction

        function void check_output(t_result seen);
            t_result want;
            if (deframed_q.size() == 0) begin
                $error("unexpected result item: kind %0d data 0x%0h", seen.kind, seen.data_byte);
                mismatches++;
                return;
            end
            want = deframed_q.pop_front();
            compare_field("kind",         16'(want.kind),         16'(seen.kind));
            compare_field("data_byte",    16'(want.data_byte),    16'(seen.data_byte));
            compare_field("byte_index",   16'(want.byte_index),   16'(seen.byte_index));
            compare_field("frame_ok",     16'(want.frame_ok),     16'(seen.frame_ok));
            compare_field("error_code",   16'(want.error_code),   16'(seen.error_code));
            compare_field("frame_seq",    want.frame_seq,         seen.frame_seq);
            compare_field("seq_gap",      16'(want.seq_gap),      16'(seen.seq_gap));
            compare_field("lost_count",   want.lost_count,        seen.lost_count);
            compare_field("computed_crc", want.computed_crc,      seen.computed_crc);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    sfd_byte_if rx_if ();
    sfd_res_if  res_if ();

    sync_frame_deframer_crc16 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    deframer_model deframer = new();
    int unsigned   rx_hold_cycles = 0;
    int unsigned   burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("sync_frame_deframer_crc16 verification failed");
        $finish;
    end

    // receiver pacing
    initial begin
        t_rx_pace    pace;
        int unsigned pace_left;
        int unsigned tick;
        res_if.ready = 1'b0;
        pace         = PACE_FULL;
        pace_left    = 0;
        tick         = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (rx_hold_cycles != 0) begin
                res_if.ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                if (pace_left == 0) begin
                    pace      = t_rx_pace'($urandom_range(0, 3));
                    pace_left = $urandom_range(16, 120);
                end
                pace_left--;
                case (pace)
                    PACE_FULL:         res_if.ready <= 1'b1;
                    PACE_COIN:         res_if.ready <= 1'($urandom_range(0, 1));
                    PACE_TWO_OF_THREE: res_if.ready <= (tick % 3 != 0);
                    default:           res_if.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_result seen;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready) begin
            seen.kind         = res_if.kind;
            seen.data_byte    = res_if.data_byte;
            seen.byte_index   = res_if.byte_index;
            seen.frame_ok     = res_if.frame_ok;
            seen.error_code   = res_if.error_code;
            seen.frame_seq    = res_if.frame_seq;
            seen.seq_gap      = res_if.seq_gap;
            seen.lost_count   = res_if.lost_count;
            seen.computed_crc = res_if.computed_crc;
            deframer.check_output(seen);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned idle;
        idle = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       idle = 0;
                3:       idle = $urandom_range(5, 20);
                default: idle = $urandom_range(1, 4);
            endcase
        end
        burst_left--;
        while (idle != 0) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
            idle--;
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        deframer.take_byte(b);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        @(negedge i_clk);
        while (deframer.deframed_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_noise(input int unsigned n);
        logic [BYTE_W-1:0] prev;
        logic [BYTE_W-1:0] b;
        prev = '0;
        repeat (n) begin
            b = BYTE_W'($urandom);
            if (prev == HDR_A && b == HDR_B) b = 8'h00;
            send_byte(b);
            prev = b;
        end
    endtask

    task automatic send_frame(input logic [SEQ_W-1:0] seq, input t_frame_fault fault,
                              input int unsigned extra_aa);
        logic [BYTE_W-1:0] fb[$];
        logic [SEQ_W-1:0]  len_val;
        logic [CRC_W-1:0]  crc_val;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] tail0;
        logic [BYTE_W-1:0] tail1;
        int unsigned       keep;
        len_val = LEN_EXPECT;
        if (fault == FR_BAD_LEN || fault == FR_BAD_LEN_CRC) begin
            case ($urandom_range(0, 3))
                0:       len_val = 16'h0000;
                1:       len_val = 16'hFFFF;
                2:       len_val = LEN_EXPECT + 16'd1;
                default: len_val = SEQ_W'($urandom);
            endcase
            if (len_val == LEN_EXPECT) len_val = len_val ^ 16'h0001;
        end
        repeat (extra_aa) fb.push_back(HDR_A);
        fb.push_back(HDR_A);
        fb.push_back(HDR_B);
        crc_val = CRC_INIT;
        b = seq[7:0];      fb.push_back(b); crc_val = deframer_model::crc16_update(crc_val, b);
        b = seq[15:8];     fb.push_back(b); crc_val = deframer_model::crc16_update(crc_val, b);
        b = len_val[7:0];  fb.push_back(b); crc_val = deframer_model::crc16_update(crc_val, b);
        b = len_val[15:8]; fb.push_back(b); crc_val = deframer_model::crc16_update(crc_val, b);
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
            b = BYTE_W'($urandom);
            fb.push_back(b);
            crc_val = deframer_model::crc16_update(crc_val, b);
        end
        if (fault == FR_BAD_CRC || fault == FR_BAD_LEN_CRC)
            crc_val = crc_val ^ CRC_W'($urandom_range(1, 16'hFFFF));
        fb.push_back(crc_val[7:0]);
        fb.push_back(crc_val[15:8]);
        tail0 = TAIL_BYTE;
        tail1 = TAIL_BYTE;
        if (fault == FR_BAD_TAIL0) tail0 = BYTE_W'($urandom);
        if (fault == FR_BAD_TAIL1) tail1 = BYTE_W'($urandom);
        if (tail0 == TAIL_BYTE && fault == FR_BAD_TAIL0) tail0 = tail0 ^ 8'h80;
        if (tail1 == TAIL_BYTE && fault == FR_BAD_TAIL1) tail1 = tail1 ^ 8'h80;
        fb.push_back(tail0);
        fb.push_back(tail1);
        keep = fb.size();
        if (fault == FR_CUT) keep = $urandom_range(3, fb.size() - 1);
        for (int k = 0; k < keep; k++) send_byte(fb[k]);
    endtask

    initial begin
        logic [BYTE_W-1:0] hunt_bytes [8];
        t_frame_fault      fault;
        hunt_bytes    = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h12, 8'hAA, 8'hAA, 8'h0D};
        fault         = FR_GOOD;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (hunt_bytes[k]) send_byte(hunt_bytes[k]);
        case ($urandom_range(0, 9))
            5:       fault = FR_BAD_LEN;
            6:       fault = FR_BAD_CRC;
            7:       fault = FR_BAD_TAIL0;
            8:       fault = FR_BAD_TAIL1;
            9:       fault = FR_BAD_LEN_CRC;
            default: fault = FR_GOOD;
        endcase
        rx_hold_cycles = LONG_HOLD;
        send_frame(SEQ_W'($urandom), fault, 2);
        wait_drained();
        send_noise(24);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (deframer.mismatches == 0 && deframer.deframed_q.size() == 0)
            $display("sync_frame_deframer_crc16 verification clean");
        else
            $display("sync_frame_deframer_crc16 verification failed");
        $finish;
    end

endmodule
